// File: rtl/swrl_pkg.sv
// Shared constants for the sliding window rate limiter.
`default_nettype none

package swrl_pkg;

    // Fixed field widths
    localparam int unsigned WINDOW_W = 32;
    localparam int unsigned LIMIT_W  = 5;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 1'd1;

    // Register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd60;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd5;

    // Sequencer state vector
    typedef logic [1:0] t_state;

endpackage : swrl_pkg

`default_nettype wire

// File: rtl/sliding_window_rate_limiter.sv
// Sliding window log rate limiter: ring of grant times with a one-compare-per-cycle expiry sequencer.
// A request is registered, its cutoff is formed in ST_CUT, and ST_CHECK retires expired head entries before deciding.
// Requests are taken one at a time: o_in_stall holds while the sequencer is not idle.
//   Expiry uses the single head comparator, which retires one expired entry per cycle.
// Reset (synchronous, active low): ring empty, head and tail at zero, window 60 s, limit 5.
//   Ring storage is not cleared; only occupied entries are ever compared.
`default_nettype none

module sliding_window_rate_limiter
    import swrl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned TIME_WIDTH  = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [WINDOW_W-1:0]   i_cfg_wdata,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [TIME_WIDTH-1:0] i_now_seconds,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_granted,
    output logic [COUNT_W-1:0]         o_in_window_count
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
    localparam int unsigned SUM_W = OCC_W + 1;

    // Sequencer codes
    localparam t_state ST_IDLE  = 2'd0;  // waiting for a request
    localparam t_state ST_CUT   = 2'd1;  // form cutoff, fetch head
    localparam t_state ST_CHECK = 2'd2;  // expire head or decide

    // Configuration
    logic [WINDOW_W-1:0]   r_window;
    logic [LIMIT_W-1:0]    r_limit;

    // Control
    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [IDX_W-1:0]      r_tail, n_tail;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic                  r_out_valid;

    // Datapath
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_cut;
    logic                  r_cut_ok;
    logic [TIME_WIDTH-1:0] r_rd;
    logic                  r_granted;
    logic [COUNT_W-1:0]    r_count;

    // Ring storage
    logic [TIME_WIDTH-1:0] mem [MAX_ENTRIES];

    logic                  in_take;
    logic                  out_take;
    logic                  pop;
    logic                  decide;
    logic                  grant;
    logic                  mem_we;
    logic [TIME_WIDTH-1:0] window_ext;
    logic [CMP_W-1:0]      limit_cfg;
    logic [CMP_W-1:0]      limit_eff;
    logic [CMP_W-1:0]      occ_ext;
    logic [CMP_W-1:0]      occ_after;
    logic [IDX_W-1:0]      head_inc;
    logic [IDX_W-1:0]      tail_inc;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign window_ext = TIME_WIDTH'(r_window);
    assign limit_cfg  = CMP_W'(r_limit);
    // limit is capped at the ring depth so the ring cannot overflow
    assign limit_eff  = (limit_cfg > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : limit_cfg;
    assign occ_ext    = CMP_W'(r_occ);

    assign head_inc = (r_head == IDX_W'(MAX_ENTRIES - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == IDX_W'(MAX_ENTRIES - 1)) ? '0 : r_tail + 1'b1;

    // Head expires when cutoff exists and head time is at or before it
    assign pop    = (r_state == ST_CHECK) && (r_occ != '0) && r_cut_ok && (r_rd <= r_cut);
    // Decide once nothing more expires and the result register can take the answer
    assign decide = (r_state == ST_CHECK) && !pop && (!r_out_valid || !i_out_stall);
    assign grant  = (occ_ext < limit_eff);
    assign mem_we = decide && grant;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        occ_after = occ_ext;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_CUT;
                end
            end
            ST_CUT: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (pop) begin
                    n_head = head_inc;
                    n_occ  = r_occ - 1'b1;
                end else if (decide) begin
                    n_state = ST_IDLE;
                    if (grant) begin
                        n_tail    = tail_inc;
                        n_occ     = r_occ + 1'b1;
                        occ_after = occ_ext + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_SECONDS: r_window <= i_cfg_wdata;
                CFG_MAX_PER_WINDOW: r_limit  <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            if (decide) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now <= i_now_seconds;
        end
        if (r_state == ST_CUT) begin
            // cutoff lies before time zero while now < window: nothing expires
            r_cut    <= r_now - window_ext;
            r_cut_ok <= (r_now >= window_ext);
        end
        if (decide) begin
            r_granted <= grant;
            r_count   <= occ_after[COUNT_W-1:0];
        end
    end

    // Ring: write at tail on grant, registered read of the next head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_tail] <= r_now;
        end
        r_rd <= mem[n_head];
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted         = r_granted;
    assign o_in_window_count = r_count;

    // Ring bookkeeping check: tail always sits occupancy entries past head
    logic [SUM_W-1:0] chk_sum;
    logic [SUM_W-1:0] chk_wrap;
    assign chk_sum  = SUM_W'(r_head) + SUM_W'(r_occ);
    assign chk_wrap = (chk_sum >= SUM_W'(MAX_ENTRIES)) ? chk_sum - SUM_W'(MAX_ENTRIES)
                                                       : chk_sum;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(MAX_ENTRIES))
        else $error("occupancy exceeds ring depth");

    a_tail_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_wrap == SUM_W'(r_tail))
        else $error("tail pointer out of step with head and occupancy");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_occ != '0))
        else $error("expiry from an empty ring");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (o_in_stall && (r_state == ST_CUT)))
        else $error("request taken without entering the sequence");

    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (decide && grant) |=> (r_occ == $past(r_occ) + 1'b1))
        else $error("grant did not record an entry");

endmodule : sliding_window_rate_limiter

`default_nettype wire
